// ----- src/ctdm_pkg.sv -----
// shared types, codes and constants for the cascaded timer with deadline compare
`default_nettype none
package ctdm_pkg;

	localparam int HALF_WIDTH_DEF = 16;

	localparam int TIME_W   = 32;
	localparam int DIV_W    = 17;
	localparam int PRE_W    = 16;
	localparam int WD_W     = 16;
	localparam int ACT_W    = 3;
	localparam int ARM_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int OUT_DATA_W = 72;

	// item actions
	localparam logic [ACT_W-1:0] ACT_TICK  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_SET   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd2;
	localparam logic [ACT_W-1:0] ACT_READ  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_KICK  = 3'd4;
	localparam logic [ACT_W-1:0] ACT_ACK   = 3'd5;

	// compare arming
	localparam logic [ARM_W-1:0] ARM_NONE = 2'd0;
	localparam logic [ARM_W-1:0] ARM_HIGH = 2'd1;
	localparam logic [ARM_W-1:0] ARM_LOW  = 2'd2;

	// status bit positions
	localparam int ST_MATCH    = 0;
	localparam int ST_OVERFLOW = 1;
	localparam int ST_WATCHDOG = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_DIVIDER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WD_RELOAD    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WD_KICK      = 2'd3;

	localparam logic [DIV_W-1:0]  DIVIDER_RST  = 17'd1;
	localparam logic [DIV_W-1:0]  DIVIDER_MAX  = 17'h10000;
	localparam logic [TIME_W-1:0] START_RST    = 32'd0;
	localparam logic [WD_W-1:0]   WD_RELOAD_RST = 16'd15;
	localparam logic [WD_W-1:0]   WD_KICK_RST   = 16'd16;

	typedef struct packed {
		logic [DIV_W-1:0]  tick_divider;
		logic [TIME_W-1:0] start_value;
		logic [WD_W-1:0]   wd_reload;
		logic [WD_W-1:0]   wd_kick;
	} cfg_t;

	typedef struct packed {
		logic [ARM_W-1:0]  armed_half;
		logic              watchdog_flag;
		logic              overflow_flag;
		logic              match_flag;
		logic [TIME_W-1:0] saved_deadline;
		logic [TIME_W-1:0] time_now;
	} result_t;

endpackage
`default_nettype wire

// ----- src/ctdm_cfg_regs.sv -----
// configuration register file with start value load strobe
`default_nettype none
module ctdm_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [ctdm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ctdm_pkg::CFG_DATA_W-1:0]     cfg_data,
	output ctdm_pkg::cfg_t                           cfg,
	output logic                                     load_start
);

	ctdm_pkg::cfg_t cfg_q;
	logic           wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_divider <= ctdm_pkg::DIVIDER_RST;
			cfg_q.start_value  <= ctdm_pkg::START_RST;
			cfg_q.wd_reload    <= ctdm_pkg::WD_RELOAD_RST;
			cfg_q.wd_kick      <= ctdm_pkg::WD_KICK_RST;
		end else if (wr) begin
			unique case (cfg_index)
				ctdm_pkg::CFG_TICK_DIVIDER: begin
					cfg_q.tick_divider <= cfg_data[ctdm_pkg::DIV_W-1:0];
				end
				ctdm_pkg::CFG_START_VALUE: begin
					cfg_q.start_value <= cfg_data;
				end
				ctdm_pkg::CFG_WD_RELOAD: begin
					cfg_q.wd_reload <= cfg_data[ctdm_pkg::WD_W-1:0];
				end
				ctdm_pkg::CFG_WD_KICK: begin
					cfg_q.wd_kick <= cfg_data[ctdm_pkg::WD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// the load strobe is registered; the halves take the new start value while it is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_start <= 1'b0;
		end else begin
			load_start <= wr && (cfg_index == ctdm_pkg::CFG_START_VALUE);
		end
	end

endmodule
`default_nettype wire

// ----- src/ctdm_core.sv -----
// timer state: prescaler, cascaded halves, compare, watchdog and status flags
`default_nettype none
module ctdm_core #(
	parameter int HALF_WIDTH = ctdm_pkg::HALF_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               exec,
	input  wire logic [ctdm_pkg::ACT_W-1:0]         action,
	input  wire logic [ctdm_pkg::TIME_W-1:0]        deadline,
	input  wire ctdm_pkg::cfg_t                     cfg,
	input  wire logic                               load_start,
	output ctdm_pkg::result_t                       result
);

	logic [ctdm_pkg::PRE_W-1:0]  pre_q, pre_d;
	logic [HALF_WIDTH-1:0]       low_q, low_d, high_q, high_d;
	logic [HALF_WIDTH-1:0]       cmp_low_q, cmp_low_d, cmp_high_q, cmp_high_d;
	logic [ctdm_pkg::ARM_W-1:0]  arm_q, arm_d;
	logic [ctdm_pkg::TIME_W-1:0] last_dl_q, last_dl_d;
	logic [2:0]                  st_q, st_d;
	logic [ctdm_pkg::WD_W-1:0]   wd_q, wd_d;

	logic [ctdm_pkg::DIV_W-1:0]  div_eff;
	logic [ctdm_pkg::DIV_W-1:0]  pre_inc;
	logic [HALF_WIDTH-1:0]       low_inc, high_inc;
	logic [ctdm_pkg::TIME_W:0]   upper;
	logic [ctdm_pkg::TIME_W:0]   high_ext;
	logic [63:0]                 start64;
	logic [63:0]                 time64;

	always_comb begin
		if (cfg.tick_divider == '0) begin
			div_eff = ctdm_pkg::DIV_W'(1);
		end else if (cfg.tick_divider > ctdm_pkg::DIVIDER_MAX) begin
			div_eff = ctdm_pkg::DIVIDER_MAX;
		end else begin
			div_eff = cfg.tick_divider;
		end
	end

	assign pre_inc  = {1'b0, pre_q} + ctdm_pkg::DIV_W'(1);
	assign low_inc  = low_q + HALF_WIDTH'(1);
	assign high_inc = high_q + HALF_WIDTH'(1);
	// deadline upper part at full value, so a wider upper part still compares right
	assign upper    = {1'b0, deadline} >> HALF_WIDTH;
	assign high_ext = (ctdm_pkg::TIME_W + 1)'(high_q);
	assign start64  = 64'(cfg.start_value);

	always_comb begin
		pre_d      = pre_q;
		low_d      = low_q;
		high_d     = high_q;
		cmp_low_d  = cmp_low_q;
		cmp_high_d = cmp_high_q;
		arm_d      = arm_q;
		last_dl_d  = last_dl_q;
		st_d       = st_q;
		wd_d       = wd_q;
		unique case (action)
			ctdm_pkg::ACT_TICK: begin
				if (pre_inc >= div_eff) begin
					pre_d = '0;
					low_d = low_inc;
					if (low_inc == '0) begin
						high_d = high_inc;
						if (high_inc == '0) begin
							st_d[ctdm_pkg::ST_OVERFLOW] = 1'b1;
						end
						if (arm_q == ctdm_pkg::ARM_HIGH && high_inc == cmp_high_q) begin
							st_d[ctdm_pkg::ST_MATCH] = 1'b1;
						end
						if (wd_q == '0) begin
							st_d[ctdm_pkg::ST_WATCHDOG] = 1'b1;
							wd_d = cfg.wd_reload;
						end else begin
							wd_d = wd_q - ctdm_pkg::WD_W'(1);
						end
					end
					if (arm_q == ctdm_pkg::ARM_LOW && low_inc == cmp_low_q) begin
						st_d[ctdm_pkg::ST_MATCH] = 1'b1;
					end
				end else begin
					pre_d = pre_inc[ctdm_pkg::PRE_W-1:0];
				end
			end
			ctdm_pkg::ACT_SET: begin
				last_dl_d = deadline;
				if (upper == high_ext) begin
					cmp_low_d = deadline[HALF_WIDTH-1:0];
					arm_d     = ctdm_pkg::ARM_LOW;
					st_d[ctdm_pkg::ST_MATCH] = 1'b0;
				end else if (upper > high_ext) begin
					cmp_high_d = upper[HALF_WIDTH-1:0];
					arm_d      = ctdm_pkg::ARM_HIGH;
					st_d[ctdm_pkg::ST_MATCH] = 1'b0;
				end
			end
			ctdm_pkg::ACT_CLEAR: begin
				arm_d = ctdm_pkg::ARM_NONE;
			end
			ctdm_pkg::ACT_KICK: begin
				wd_d = cfg.wd_kick;
			end
			ctdm_pkg::ACT_ACK: begin
				st_d = '0;
			end
			default: begin
				// read and unused codes leave the state alone
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q      <= '0;
			low_q      <= '0;
			high_q     <= '0;
			cmp_low_q  <= '0;
			cmp_high_q <= '0;
			arm_q      <= ctdm_pkg::ARM_NONE;
			last_dl_q  <= '0;
			st_q       <= '0;
			wd_q       <= ctdm_pkg::WD_KICK_RST;
		end else if (load_start) begin
			low_q  <= start64[HALF_WIDTH-1:0];
			high_q <= start64[2*HALF_WIDTH-1:HALF_WIDTH];
		end else if (exec) begin
			pre_q      <= pre_d;
			low_q      <= low_d;
			high_q     <= high_d;
			cmp_low_q  <= cmp_low_d;
			cmp_high_q <= cmp_high_d;
			arm_q      <= arm_d;
			last_dl_q  <= last_dl_d;
			st_q       <= st_d;
			wd_q       <= wd_d;
		end
	end

	// snapshot after the item is applied
	assign time64 = 64'({high_d, low_d});

	always_comb begin
		result.time_now       = time64[ctdm_pkg::TIME_W-1:0];
		result.saved_deadline = last_dl_d;
		result.match_flag     = st_d[ctdm_pkg::ST_MATCH];
		result.overflow_flag  = st_d[ctdm_pkg::ST_OVERFLOW];
		result.watchdog_flag  = st_d[ctdm_pkg::ST_WATCHDOG];
		result.armed_half     = arm_d;
	end

	a_ack_clears: assert property (@(posedge clk) disable iff (!arst_n)
		exec && !load_start && action == ctdm_pkg::ACT_ACK |=> st_q == '0)
		else $error("flags not cleared by acknowledge");

	a_clear_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		exec && !load_start && action == ctdm_pkg::ACT_CLEAR |=> arm_q == ctdm_pkg::ARM_NONE)
		else $error("compare still armed after clear");

	a_kick_loads: assert property (@(posedge clk) disable iff (!arst_n)
		exec && !load_start && action == ctdm_pkg::ACT_KICK |=> wd_q == $past(cfg.wd_kick))
		else $error("watchdog not loaded by kick");

	a_time_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!exec && !load_start |=> $stable(low_q) && $stable(high_q))
		else $error("time changed without an item");

endmodule
`default_nettype wire

// ----- src/cascaded_timer_deadline_match_top.sv -----
// Cascaded 32-bit time base with deadline compare and watchdog. One item is taken per clock
// cycle at full rate unless the output register holds an item that is not taken; each item
// gives exactly one result. The item is held in an input register, the timer state and the
// result are computed from it combinationally and the result lands in an output register.
// Input ready falls only while both registers hold items and the output item is not taken.
// Configuration writes are always ready; a start value write raises a registered load strobe
// that loads both halves.
`default_nettype none
module cascaded_timer_deadline_match_top #(
	parameter int HALF_WIDTH = ctdm_pkg::HALF_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [ctdm_pkg::TIME_W-1:0]         s_tdata,  // deadline
	input  wire logic [ctdm_pkg::ACT_W-1:0]          s_tuser,  // action
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// time_now[31:0], saved_deadline[63:32], match_flag[64], overflow_flag[65],
	// watchdog_flag[66], armed_half[68:67], zero[71:69]
	output logic [ctdm_pkg::OUT_DATA_W-1:0]          m_tdata,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [ctdm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ctdm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int RES_W = $bits(ctdm_pkg::result_t);

	ctdm_pkg::cfg_t               cfg;
	ctdm_pkg::result_t            result;
	logic                         load_start;
	logic                         valid_s1;
	logic [ctdm_pkg::ACT_W-1:0]   action_s1;
	logic [ctdm_pkg::TIME_W-1:0]  deadline_s1;
	logic                         advance;
	logic                         exec;
	logic                         out_valid_q;
	ctdm_pkg::result_t            out_q;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign exec     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1   <= s_tuser;
			deadline_s1 <= s_tdata;
		end
	end

	ctdm_cfg_regs u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cfg        (cfg),
		.load_start (load_start)
	);

	ctdm_core #(
		.HALF_WIDTH (HALF_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.exec       (exec),
		.action     (action_s1),
		.deadline   (deadline_s1),
		.cfg        (cfg),
		.load_start (load_start),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = ctdm_pkg::OUT_DATA_W'({{(ctdm_pkg::OUT_DATA_W - RES_W){1'b0}}, out_q});

endmodule
`default_nettype wire
